// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/i2cm_pkg.sv =====
// Types, codes and timing helpers shared by the I2C master bit engine files.
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BC_W = $clog2(BITS_PER_BYTE + 1);

  // Command codes of a request.
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_HOLD      = 2'd0;
  localparam logic [1:0] REG_BIT_PHASE = 2'd1;
  localparam logic [1:0] REG_READ_HIGH = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'h0001,
    ST_ST_A    = 15'h0002,
    ST_ST_B    = 15'h0004,
    ST_SP_A    = 15'h0008,
    ST_SP_B    = 15'h0010,
    ST_WR_LO   = 15'h0020,
    ST_WR_HI   = 15'h0040,
    ST_WR_LO2  = 15'h0080,
    ST_RD_LO   = 15'h0100,
    ST_RD_HI   = 15'h0200,
    ST_AK_LO   = 15'h0400,
    ST_AK_HI   = 15'h0800,
    ST_WA_REL  = 15'h1000,
    ST_WA_HI   = 15'h2000,
    ST_WA_POLL = 15'h4000
  } step_t;

  typedef struct packed {
    logic [7:0] hold;
    logic [7:0] bit_phase;
    logic [7:0] read_high;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_failed;
  } seq_res_t;

  // Length of a phase in ticks; a programmed zero behaves as one tick.
  function automatic logic [7:0] phase_len(step_t s, cfg_t c);
    logic [7:0] v;
    unique case (s)
      ST_ST_A, ST_ST_B, ST_SP_A, ST_SP_B: v = c.hold;
      ST_RD_HI:                           v = c.read_high;
      ST_WA_REL, ST_WA_HI:                v = 8'd1;
      default:                            v = c.bit_phase;
    endcase
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// ===== hdl/i2cm_seq.sv =====
// Bus sequencer: phase state, counters, shift register and line drive of the engine.
module i2cm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_en,
  input  i2cm_pkg::cfg_t    cfg,
  input  logic [2:0]        command,
  input  logic [7:0]        write_data,
  input  logic              ack_after_read,
  input  logic              sda_sample,
  output i2cm_pkg::seq_res_t res
);
  import i2cm_pkg::*;

  step_t           step_r, step_nxt;
  logic [7:0]      tick_r, tick_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt, bc_inc;
  logic [7:0]      shift_r, shift_nxt;
  logic [7:0]      poll_r, poll_nxt;
  logic            scl_r, scl_nxt, sda_r, sda_nxt, en_r, en_nxt;
  logic            ackc_r, ackc_nxt;
  logic            fail_r, fail_nxt;
  logic [7:0]      rd_r, rd_nxt;
  logic            done;
  logic [7:0]      plen;
  logic [7:0]      tick_base;

  assign plen   = phase_len(step_r, cfg);
  assign bc_inc = bc_r + BC_W'(1);

  always_comb begin
    step_nxt  = step_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    en_nxt    = en_r;
    ackc_nxt  = ackc_r;
    fail_nxt  = fail_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    if (step_r == ST_IDLE) begin
      bc_nxt = '0;
      unique case (command)
        CMD_START: begin
          step_nxt = ST_ST_A;
          scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b1;
        end
        CMD_STOP: begin
          step_nxt = ST_SP_A;
          scl_nxt = 1'b0; sda_nxt = 1'b0; en_nxt = 1'b1;
        end
        CMD_WRITE: begin
          shift_nxt = write_data;
          step_nxt  = ST_WR_LO;
          scl_nxt = 1'b0; sda_nxt = write_data[7]; en_nxt = 1'b1;
        end
        CMD_READ: begin
          shift_nxt = '0;
          ackc_nxt  = ack_after_read;
          step_nxt  = ST_RD_LO;
          scl_nxt = 1'b0; sda_nxt = 1'b1; en_nxt = 1'b0;
        end
        CMD_WAIT_ACK: begin
          poll_nxt = '0;
          step_nxt = ST_WA_REL;
          scl_nxt = 1'b0; sda_nxt = 1'b1; en_nxt = 1'b0;
        end
        default: ;
      endcase
    end else begin
      if (step_r != ST_WA_POLL && tick_r >= plen) begin
        unique case (step_r)
          ST_ST_A: begin
            step_nxt = ST_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0; en_nxt = 1'b1;
          end
          ST_ST_B: begin
            step_nxt = ST_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b0; en_nxt = 1'b1;
            done = 1'b1;
          end
          ST_SP_A: begin
            step_nxt = ST_SP_B; scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b1;
          end
          ST_SP_B: begin
            step_nxt = ST_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b1;
            done = 1'b1;
          end
          ST_WR_LO: begin
            step_nxt = ST_WR_HI; scl_nxt = 1'b1; en_nxt = 1'b1;
          end
          ST_WR_HI: begin
            step_nxt = ST_WR_LO2; scl_nxt = 1'b0; en_nxt = 1'b1;
          end
          ST_WR_LO2: begin
            bc_nxt = bc_inc;
            if (bc_inc < BC_W'(BITS_PER_BYTE)) begin
              shift_nxt = {shift_r[6:0], 1'b0};
              step_nxt  = ST_WR_LO;
              scl_nxt = 1'b0; sda_nxt = shift_r[6]; en_nxt = 1'b1;
            end else begin
              step_nxt = ST_IDLE; scl_nxt = 1'b0; en_nxt = 1'b1;
              done = 1'b1;
            end
          end
          ST_RD_LO: begin
            // Data is sampled on the tick SCL rises.
            shift_nxt = {shift_r[6:0], sda_sample};
            step_nxt  = ST_RD_HI;
            scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b0;
          end
          ST_RD_HI: begin
            bc_nxt = bc_inc;
            if (bc_inc < BC_W'(BITS_PER_BYTE)) begin
              step_nxt = ST_RD_LO;
              scl_nxt = 1'b0; sda_nxt = 1'b1; en_nxt = 1'b0;
            end else begin
              rd_nxt   = shift_r;
              step_nxt = ST_AK_LO;
              scl_nxt = 1'b0; sda_nxt = ~ackc_r; en_nxt = 1'b1;
            end
          end
          ST_AK_LO: begin
            step_nxt = ST_AK_HI; scl_nxt = 1'b1; en_nxt = 1'b1;
          end
          ST_AK_HI: begin
            step_nxt = ST_IDLE; scl_nxt = 1'b0; en_nxt = 1'b1;
            done = 1'b1;
          end
          ST_WA_REL: begin
            step_nxt = ST_WA_HI; scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b0;
          end
          ST_WA_HI: begin
            step_nxt = ST_WA_POLL; scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b0;
          end
          default: step_nxt = ST_IDLE;
        endcase
      end
      // Polling starts on the same tick the poll phase is entered.
      if (step_nxt == ST_WA_POLL) begin
        if (!sda_sample) begin
          fail_nxt = 1'b0;
          step_nxt = ST_IDLE;
          scl_nxt = 1'b0; sda_nxt = 1'b1; en_nxt = 1'b0;
          done = 1'b1;
        end else if (poll_r >= cfg.ack_timeout) begin
          fail_nxt = 1'b1;
          step_nxt = ST_SP_A;
          scl_nxt = 1'b0; sda_nxt = 1'b0; en_nxt = 1'b1;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end
    end
  end

  // Every phase entry changes the step, so a change restarts the tick count.
  assign tick_base = (step_nxt != step_r) ? 8'd0 : tick_r;

  always_comb begin
    tick_nxt = tick_base;
    if (step_nxt != ST_IDLE && step_nxt != ST_WA_POLL && tick_base != 8'hFF) begin
      tick_nxt = tick_base + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      tick_r  <= '0;
      bc_r    <= '0;
      shift_r <= '0;
      poll_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      en_r    <= 1'b1;
      ackc_r  <= 1'b0;
      fail_r  <= 1'b0;
      rd_r    <= '0;
    end else if (tick_en) begin
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      bc_r    <= bc_nxt;
      shift_r <= shift_nxt;
      poll_r  <= poll_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      en_r    <= en_nxt;
      ackc_r  <= ackc_nxt;
      fail_r  <= fail_nxt;
      rd_r    <= rd_nxt;
    end
  end

  always_comb begin
    res.scl_level        = scl_nxt;
    res.sda_level        = sda_nxt;
    res.sda_drive_enable = en_nxt;
    res.busy_res         = (step_nxt != ST_IDLE);
    res.done_res         = done;
    res.read_byte        = rd_nxt;
    res.ack_failed       = fail_nxt;
  end

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: configuration, handshakes and result register.
// Latency: the result of a request is valid in the cycle after the request is accepted.
// Throughput: one request (one bus tick) per clock cycle unless stalled; the phase state
// advances in a single pass of logic between the sequencer and result registers.
// Reset (rst_n low, synchronous): sequencer idle, SCL and SDA driven high, counters and
// flags cleared, no result pending, timing registers back to 4, 2, 1 and 250.
module i2c_master_bit_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_write_data,
  input  logic       in_ack_after_read,
  input  logic       in_sda_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_sda_drive_enable,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_byte,
  output logic       out_ack_failed
);
  import i2cm_pkg::*;

  cfg_t     cfg_r;
  seq_res_t seq_res;
  seq_res_t res_r;
  logic     out_valid_r;
  logic     accept;

  // The result register parts the two channels: a new request is taken whenever the
  // register is empty or its content leaves in the same cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Timing registers. The user must write them only while the engine is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold        <= 8'd4;
      cfg_r.bit_phase   <= 8'd2;
      cfg_r.read_high   <= 8'd1;
      cfg_r.ack_timeout <= 8'd250;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_HOLD:      cfg_r.hold        <= cfg_data;
        REG_BIT_PHASE: cfg_r.bit_phase   <= cfg_data;
        REG_READ_HIGH: cfg_r.read_high   <= cfg_data;
        REG_TIMEOUT:   cfg_r.ack_timeout <= cfg_data;
      endcase
    end
  end

  // The sequencer advances by one tick for each accepted request and presents the
  // line levels and status that hold after that tick.
  i2cm_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_en        (accept),
    .cfg            (cfg_r),
    .command        (in_command),
    .write_data     (in_write_data),
    .ack_after_read (in_ack_after_read),
    .sda_sample     (in_sda_sample),
    .res            (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The payload is loaded only on an accepted request, so a stalled result holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= seq_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_scl_level        = res_r.scl_level;
  assign out_sda_level        = res_r.sda_level;
  assign out_sda_drive_enable = res_r.sda_drive_enable;
  assign out_busy_res         = res_r.busy_res;
  assign out_done_res         = res_r.done_res;
  assign out_read_byte        = res_r.read_byte;
  assign out_ack_failed       = res_r.ack_failed;

endmodule

// ===== hdl/i2cm_checker.sv =====
// Port-level checker for the I2C master bit engine and its bind statement.
`include "assert_macros.svh"

module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_read_byte
);

  logic prev_busy_r;

  // Busy status of the last result taken from the output channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_busy_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_busy_r <= out_busy_res;
    end
  end

  `ASSERT_IMP(a_done_not_busy, out_valid && out_done_res, !out_busy_res, "done while busy")
  `ASSERT_IMP(a_done_after_busy, out_valid && out_done_res, prev_busy_r, "done without sequence")
  `ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")
  `ASSERT_NXT(a_out_hold, out_valid && out_stall,
              out_valid && $stable(out_read_byte) && $stable(out_busy_res), "stalled result moved")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
